// ===== hdl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and constants of the IPv4/TCP SYN header generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

  // packet layout
  localparam int unsigned PKT_WORDS   = 10;
  localparam int unsigned IDX_W       = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_WORDS - 1);

  // fixed header fields
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
  localparam logic [15:0] IP_ID          = 16'd54321;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam logic [15:0] TCP_LEN        = 16'd20;
  localparam logic [3:0]  TCP_DOFF       = 4'd5;
  localparam logic [11:0] TCP_FLAGS_SYN  = 12'h002;
  localparam logic [15:0] TCP_WINDOW     = 16'd5840;

  // partial sums of the 16-bit words that never change
  localparam int unsigned SUM_W = 19;
  localparam logic [SUM_W-1:0] IP_SUM_BASE =
    SUM_W'(IP_VER_IHL_TOS) + SUM_W'(IP_TOTAL_LEN) + SUM_W'(IP_ID) +
    SUM_W'({IP_TTL, IP_PROTO_TCP});
  localparam logic [SUM_W-1:0] TCP_SUM_BASE =
    SUM_W'({8'd0, IP_PROTO_TCP}) + SUM_W'(TCP_LEN) +
    SUM_W'({TCP_DOFF, TCP_FLAGS_SYN}) + SUM_W'(TCP_WINDOW);

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one classified request with finished checksums
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } pkt_entry_t;

  // front to queue
  typedef struct packed {
    logic       push;
    pkt_entry_t entry;
  } q_push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/tcp_syn_header_generator.sv =====
// ----------------------------------------------------------------------------
// tcp_syn_header_generator
// Builds a 40-byte IPv4 + TCP SYN packet with both checksums filled in.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its packet leaves
// as ten 32-bit words in network byte order, word 0 first, one word per
// cycle with out_valid high and out_last_word marking word 9; the receiver
// cannot stall the stream. A request reaches the first word through the
// checksum register, the queue, the serializer's request register and the
// output register. The word output limits the sustained request rate; a
// two-entry queue lets requests be taken while earlier packets stream out,
// and busy rises only when it and the checksum stage are both full.
`default_nettype none

module tcp_syn_header_generator import tsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_destination_port,
  output logic             out_valid,
  output logic [31:0]      out_packet_word,
  output logic [3:0]       out_word_index,
  output logic             out_last_word
);

  q_push_t    q_push;
  q_stat_t    q_stat;
  pkt_entry_t head;
  logic       pop;

  // checksum front
  tsg_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_source_port         (in_source_port),
    .in_destination_port    (in_destination_port),
    .q_stat                 (q_stat),
    .q_push                 (q_push)
  );

  // decoupling queue
  tsg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  // word serializer
  tsg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_packet_word (out_packet_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

// ===== hdl/tsg_front.sv =====
// ----------------------------------------------------------------------------
// tsg_front
// Accepts a request, sums the header words and finishes both checksums.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_front import tsg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_destination_port,
  input  wire q_stat_t     q_stat,
  output q_push_t          q_push
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [31:0]      src_r, dst_r;
  logic [15:0]      sport_r, dport_r;
  logic [SUM_W-1:0] ip_sum_r, tcp_sum_r;
  logic             accept, push;
  logic [16:0]      ip_f1, tcp_f1;
  logic [16:0]      ip_f2, tcp_f2;

  // stage holds while the queue is full
  assign push   = s1_valid_r && !q_stat.full;
  assign busy   = s1_valid_r && q_stat.full;
  assign accept = start && !busy;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // partial sums of the variable words on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      src_r     <= in_source_address;
      dst_r     <= in_destination_address;
      sport_r   <= in_source_port;
      dport_r   <= in_destination_port;
      ip_sum_r  <= IP_SUM_BASE +
                   SUM_W'(in_source_address[31:16]) + SUM_W'(in_source_address[15:0]) +
                   SUM_W'(in_destination_address[31:16]) +
                   SUM_W'(in_destination_address[15:0]);
      tcp_sum_r <= TCP_SUM_BASE +
                   SUM_W'(in_source_address[31:16]) + SUM_W'(in_source_address[15:0]) +
                   SUM_W'(in_destination_address[31:16]) +
                   SUM_W'(in_destination_address[15:0]) +
                   SUM_W'(in_source_port) + SUM_W'(in_destination_port);
    end
  end

  // end-around carry fold, two passes cover the 19-bit sum
  assign ip_f1  = 17'(ip_sum_r[15:0]) + 17'(ip_sum_r[SUM_W-1:16]);
  assign ip_f2  = 17'(ip_f1[15:0]) + 17'(ip_f1[16]);
  assign tcp_f1 = 17'(tcp_sum_r[15:0]) + 17'(tcp_sum_r[SUM_W-1:16]);
  assign tcp_f2 = 17'(tcp_f1[15:0]) + 17'(tcp_f1[16]);

  always_comb begin
    q_push.push           = push;
    q_push.entry.src      = src_r;
    q_push.entry.dst      = dst_r;
    q_push.entry.sport    = sport_r;
    q_push.entry.dport    = dport_r;
    q_push.entry.ip_csum  = ~ip_f2[15:0];
    q_push.entry.tcp_csum = ~tcp_f2[15:0];
  end

endmodule

`default_nettype wire

// ===== hdl/tsg_queue.sv =====
// ----------------------------------------------------------------------------
// tsg_queue
// Small FIFO that decouples the checksum front from the word back.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_queue import tsg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire q_push_t q_push,
  input  wire logic    pop,
  output q_stat_t      q_stat,
  output pkt_entry_t   head
);

  pkt_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = q_push.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tsg_back.sv =====
// ----------------------------------------------------------------------------
// tsg_back
// Walks one queued request through its ten packet words, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_back import tsg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire q_stat_t    q_stat,
  input  wire pkt_entry_t head,
  output logic            pop,
  output logic            out_valid,
  output logic [31:0]     out_packet_word,
  output logic [3:0]      out_word_index,
  output logic            out_last_word
);

  pkt_entry_t       cur_r;
  logic             act_r, act_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             at_last;
  logic             out_valid_r;
  logic [31:0]      word_r;
  logic [IDX_W-1:0] word_idx_r;
  logic             last_r;
  logic [31:0]      word;

  assign at_last = (idx_r == LAST_IDX);
  assign pop     = (!act_r || at_last) && !q_stat.empty;

  // word counter and next-request load
  always_comb begin
    act_nxt = act_r;
    idx_nxt = idx_r;
    if (pop) begin
      act_nxt = 1'b1;
      idx_nxt = '0;
    end else if (act_r && at_last) begin
      act_nxt = 1'b0;
    end else if (act_r) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  // packet word select
  always_comb begin
    unique case (idx_r)
      4'd0:    word = {IP_VER_IHL_TOS, IP_TOTAL_LEN};
      4'd1:    word = {IP_ID, 16'h0000};
      4'd2:    word = {IP_TTL, IP_PROTO_TCP, cur_r.ip_csum};
      4'd3:    word = cur_r.src;
      4'd4:    word = cur_r.dst;
      4'd5:    word = {cur_r.sport, cur_r.dport};
      4'd8:    word = {TCP_DOFF, TCP_FLAGS_SYN, TCP_WINDOW};
      4'd9:    word = {cur_r.tcp_csum, 16'h0000};
      default: word = 32'h0000_0000;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    word_r     <= word;
    word_idx_r <= idx_r;
    last_r     <= at_last;
  end

  assign out_valid       = out_valid_r;
  assign out_packet_word = word_r;
  assign out_word_index  = word_idx_r;
  assign out_last_word   = out_valid_r && last_r;

endmodule

`default_nettype wire

// ===== hdl/tsg_checker.sv =====
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks on the packet word stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic [31:0] out_packet_word,
  input wire logic [3:0]  out_word_index,
  input wire logic        out_last_word
);

  // last flag only on word nine of a valid transaction
  a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word == (out_valid && out_word_index == 4'd9))
    else $error("last_word flag does not match word nine");

  // words of a packet come back to back in order
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_index != 4'd9 |=>
      out_valid && out_word_index == $past(out_word_index) + 4'd1)
    else $error("packet word sequence broken");

  // a burst always opens with word zero
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_word_index == 4'd0)
    else $error("packet does not start at word zero");

  // first word carries version, ihl and total length
  a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_index == 4'd0 |-> out_packet_word == 32'h4500_0028)
    else $error("bad first ip header word");

endmodule

bind tcp_syn_header_generator tsg_checker u_tsg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_packet_word (out_packet_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

`default_nettype wire

// ===== tb/sv/tcp_syn_header_generator_test.sv =====
// ----------------------------------------------------------------------------
// tcp_syn_header_generator_test
// Self-checking bench for the IPv4/TCP SYN header generator. Requests are
// queued up front and sent in random bursts. Each accepted request is
// turned into its ten expected packet words, and the output stream is
// checked word by word against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tcp_syn_header_generator_test;

  // fixed packet fields, big-endian words
  localparam int unsigned SYN_WORDS    = 10;
  localparam logic [31:0] WORD_VER_LEN = 32'h4500_0028;
  localparam logic [31:0] WORD_ID      = {16'd54321, 16'h0000};
  localparam logic [31:0] WORD_TTL     = {8'd64, 8'd6, 16'h0000};
  localparam logic [31:0] WORD_DOFF    = {4'd5, 12'h002, 16'd5840};
  localparam logic [31:0] PSEUDO_TAIL  = {8'd0, 8'd6, 16'd20};
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } syn_request_t;

  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        last;
  } syn_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_source_address = '0;
  logic [31:0] in_destination_address = '0;
  logic [15:0] in_source_port = '0;
  logic [15:0] in_destination_port = '0;
  logic        out_valid;
  logic [31:0] out_packet_word;
  logic [3:0]  out_word_index;
  logic        out_last_word;

  syn_request_t pending_requests[$];
  syn_word_t    syn_words_due[$];
  logic         took_item = 1'b0;
  int           burst_left = 1;
  int           gap_left = 0;
  int           failures = 0;

  tcp_syn_header_generator i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_source_port         (in_source_port),
    .in_destination_port    (in_destination_port),
    .out_valid              (out_valid),
    .out_packet_word        (out_packet_word),
    .out_word_index         (out_word_index),
    .out_last_word          (out_last_word)
  );

  always #5 clk = ~clk;

  // end-around-carry fold of a 16-bit word sum
  function automatic logic [15:0] fold_sum(input logic [31:0] acc);
    logic [31:0] s;
    s = acc;
    while (s[31:16] != 16'h0000) s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
    return s[15:0];
  endfunction

  // ones'-complement sum over the ip header, checksum field at zero
  function automatic logic [15:0] ip_header_sum(input logic [31:0] src, input logic [31:0] dst);
    logic [31:0] w[5];
    logic [31:0] acc;
    w = '{WORD_VER_LEN, WORD_ID, WORD_TTL, src, dst};
    acc = '0;
    foreach (w[k]) acc += w[k][31:16] + w[k][15:0];
    return fold_sum(acc);
  endfunction

  // ones'-complement sum over pseudo header plus tcp header
  function automatic logic [15:0] tcp_segment_sum(input logic [31:0] src,
                                                  input logic [31:0] dst,
                                                  input logic [15:0] sport,
                                                  input logic [15:0] dport);
    logic [31:0] w[8];
    logic [31:0] acc;
    w = '{src, dst, PSEUDO_TAIL, {sport, dport}, 32'h0, 32'h0, WORD_DOFF, 32'h0};
    acc = '0;
    foreach (w[k]) acc += w[k][31:16] + w[k][15:0];
    return fold_sum(acc);
  endfunction

  // expected ten-word packet for one accepted transaction
  function automatic void push_syn_packet(input syn_request_t req);
    logic [31:0] w[SYN_WORDS];
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
    syn_word_t   e;
    ip_csum  = ~ip_header_sum(req.src, req.dst);
    tcp_csum = ~tcp_segment_sum(req.src, req.dst, req.sport, req.dport);
    w = '{WORD_VER_LEN, WORD_ID, WORD_TTL | {16'h0000, ip_csum}, req.src, req.dst,
          {req.sport, req.dport}, 32'h0, 32'h0, WORD_DOFF, {tcp_csum, 16'h0000}};
    for (int k = 0; k < SYN_WORDS; k++) begin
      e.word  = w[k];
      e.index = 4'(k);
      e.last  = (k == SYN_WORDS - 1);
      syn_words_due.push_back(e);
    end
  endfunction

  // tune the destination so the ip checksum comes out zero
  function automatic syn_request_t zero_ip_csum(input syn_request_t req);
    syn_request_t r;
    r = req;
    r.dst[15:0] = 16'h0000;
    r.dst[15:0] = 16'hffff - ip_header_sum(r.src, r.dst);
    return r;
  endfunction

  // tune the destination port so the tcp checksum comes out zero
  function automatic syn_request_t zero_tcp_csum(input syn_request_t req);
    syn_request_t r;
    r = req;
    r.dport = 16'hffff - tcp_segment_sum(r.src, r.dst, r.sport, 16'h0000);
    return r;
  endfunction

  function automatic syn_request_t random_request();
    syn_request_t r;
    r.src   = $urandom();
    r.dst   = $urandom();
    r.sport = 16'($urandom());
    r.dport = 16'($urandom());
    return r;
  endfunction

  // field value from the edges or from anywhere in its range
  function automatic logic [31:0] edge_value(input logic [31:0] top);
    case ($urandom_range(0, 3))
      0: return 32'h0;
      1: return top;
      default: return $urandom() & top;
    endcase
  endfunction

  task automatic report_failure(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    failures++;
  endtask

  // driver: bursts of transactions with random gaps, noise while idle
  always @(negedge clk) begin
    syn_request_t noise;
    noise = random_request();
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (took_item) begin
        void'(pending_requests.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          case ($urandom_range(0, 2))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 30);
          endcase
        end
      end
      if (gap_left == 0 && pending_requests.size() != 0) begin
        start                  <= 1'b1;
        in_source_address      <= pending_requests[0].src;
        in_destination_address <= pending_requests[0].dst;
        in_source_port         <= pending_requests[0].sport;
        in_destination_port    <= pending_requests[0].dport;
      end else begin
        if (gap_left > 0) gap_left--;
        start                  <= 1'b0;
        in_source_address      <= noise.src;
        in_destination_address <= noise.dst;
        in_source_port         <= noise.sport;
        in_destination_port    <= noise.dport;
      end
    end
  end

  // monitor: predict on accepted transactions, check every output word
  always @(posedge clk) begin
    syn_request_t req;
    syn_word_t    e;
    took_item <= rst_n && start && !busy;
    if (rst_n) begin
      if (start && !busy) begin
        req = '{in_source_address, in_destination_address, in_source_port,
                in_destination_port};
        push_syn_packet(req);
      end
      if (out_valid === 1'b1) begin
        if (syn_words_due.size() == 0) begin
          report_failure($sformatf("unexpected word %h index %0d", out_packet_word,
                                   out_word_index));
        end else begin
          e = syn_words_due.pop_front();
          if (out_packet_word !== e.word)
            report_failure($sformatf("word %0d: packet_word %h, want %h", e.index,
                                     out_packet_word, e.word));
          if (out_word_index !== e.index)
            report_failure($sformatf("word %0d: word_index %0d", e.index, out_word_index));
          if (out_last_word !== e.last)
            report_failure($sformatf("word %0d: last_word %b, want %b", e.index,
                                     out_last_word, e.last));
        end
      end else if (out_valid !== 1'b0) begin
        report_failure("out_valid unknown");
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    syn_request_t r;
    // extremes of every field, alternating bit patterns and a few fixed values
    pending_requests.push_back('{32'h0, 32'h0, 16'h0, 16'h0});
    pending_requests.push_back('{32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff});
    pending_requests.push_back('{32'hffff_ffff, 32'h0, 16'h0, 16'hffff});
    pending_requests.push_back('{32'h0, 32'hffff_ffff, 16'hffff, 16'h0});
    pending_requests.push_back('{32'h5555_5555, 32'haaaa_aaaa, 16'h5555, 16'haaaa});
    pending_requests.push_back('{32'haaaa_aaaa, 32'h5555_5555, 16'haaaa, 16'h5555});
    pending_requests.push_back('{32'h8000_0001, 32'h0000_8000, 16'h8000, 16'h0001});
    pending_requests.push_back('{32'hc0a8_0001, 32'h0a00_0001, 16'd1234, 16'd80});
    // checksums that come out zero
    pending_requests.push_back(zero_ip_csum('{32'h0, 32'h0, 16'h0, 16'h0}));
    pending_requests.push_back(zero_ip_csum('{32'hffff_ffff, 32'hffff_0000, 16'h1, 16'h2}));
    pending_requests.push_back(zero_tcp_csum('{32'h0, 32'h0, 16'h0, 16'h0}));
    pending_requests.push_back(zero_tcp_csum('{32'hffff_ffff, 32'hffff_ffff, 16'hffff,
                                               16'h0}));
    for (int n = 0; n < 4; n++) begin
      pending_requests.push_back(zero_ip_csum(random_request()));
      pending_requests.push_back(zero_tcp_csum(random_request()));
    end
    pending_requests.push_back(zero_tcp_csum(zero_ip_csum(random_request())));
    // random part
    for (int n = 0; n < 89; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          r.src   = edge_value(32'hffff_ffff);
          r.dst   = edge_value(32'hffff_ffff);
          r.sport = 16'(edge_value(32'h0000_ffff));
          r.dport = 16'(edge_value(32'h0000_ffff));
        end
        2: r = zero_ip_csum(random_request());
        3: r = zero_tcp_csum(random_request());
        default: r = random_request();
      endcase
      pending_requests.push_back(r);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || syn_words_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("tcp_syn_header_generator_test passed");
    end else begin
      $display("tcp_syn_header_generator_test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("tcp_syn_header_generator_test failed");
    $finish;
  end

endmodule
